// ===== design/layer_normalization_top_assert.svh =====
// ----------------------------------------------------------------------------
// Layer normalization assertion macros
// Implication and next-cycle checks, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LAYER_NORMALIZATION_TOP_ASSERT_SVH
`define LAYER_NORMALIZATION_TOP_ASSERT_SVH

// check a consequence in the same cycle
`define LNORM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("layer normalization check failed");

// check a consequence in the following cycle
`define LNORM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("layer normalization check failed");

`endif

// ===== design/lnorm_pkg.sv =====
// ----------------------------------------------------------------------------
// Layer normalization package
// Controller states, command and status groups, register codes and limits.
// ----------------------------------------------------------------------------
package lnorm_pkg;

    localparam int LEN_W      = 7;
    localparam int EPS_W      = 16;
    localparam int NORM_W     = 16;
    localparam int FRAC_SHIFT = 12;
    localparam int SRCH_BITS  = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 2'd1;

    localparam logic [LEN_W-1:0]  LEN_RESET = 7'd64;
    localparam logic [EPS_W-1:0]  EPS_RESET = 16'd1;
    localparam logic [NORM_W-1:0] POS_LIM   = 16'd32767;
    localparam logic [NORM_W-1:0] NEG_LIM   = 16'd32768;

    typedef enum logic [3:0] {
        S_LOAD,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_VAR_RD,
        S_VAR_DIFF,
        S_VAR_SQ,
        S_VAR_ACC,
        S_VDIV_GO,
        S_VDIV_WAIT,
        S_OUT_RD,
        S_OUT_DIFF,
        S_OUT_SQ,
        S_OUT_SRCH,
        S_OUT_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_var;
        logic take_mean;
        logic take_var;
        logic idx_clr;
        logic idx_inc;
        logic rd;
        logic diff;
        logic sq;
        logic acc;
        logic t2;
        logic srch;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_last;
        logic div_done;
        logic idx_last;
        logic srch_last;
        logic out_free;
    } t_sts;

endpackage

// ===== design/lnorm_div.sv =====
// ----------------------------------------------------------------------------
// Layer normalization divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnorm_div #(
    parameter int DW  = 39,
    parameter int DVW = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic [DW-1:0]  o_quotient,
    output logic           o_rem_nz,
    output logic           o_done
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]  r_q;
    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_dvs;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DVW:0]   w_sh;
    logic [DVW:0]   w_sub;
    logic           w_ge;

    assign w_sh  = {r_rem, r_q[DW-1]};
    assign w_ge  = w_sh >= {1'b0, r_dvs};
    assign w_sub = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DVW-1:0] : w_sh[DVW-1:0];
        end
    end

    assign o_quotient = r_q;
    assign o_rem_nz   = |r_rem;
    assign o_done     = r_done;

endmodule

// ===== design/lnorm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Layer normalization controller
// Sequences load, mean, variance and output passes over the sample store.
// ----------------------------------------------------------------------------
module lnorm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sample_valid,
    input  lnorm_pkg::t_sts   i_sts,
    output logic              o_sample_ready,
    output lnorm_pkg::t_cmd   o_cmd
);

    lnorm_pkg::t_state r_state;
    lnorm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lnorm_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lnorm_pkg::S_LOAD: begin
                if (i_sample_valid && i_sts.in_last) n_state = lnorm_pkg::S_MEAN_GO;
            end
            lnorm_pkg::S_MEAN_GO:  n_state = lnorm_pkg::S_MEAN_WAIT;
            lnorm_pkg::S_MEAN_WAIT: begin
                if (i_sts.div_done) n_state = lnorm_pkg::S_VAR_RD;
            end
            lnorm_pkg::S_VAR_RD:   n_state = lnorm_pkg::S_VAR_DIFF;
            lnorm_pkg::S_VAR_DIFF: n_state = lnorm_pkg::S_VAR_SQ;
            lnorm_pkg::S_VAR_SQ:   n_state = lnorm_pkg::S_VAR_ACC;
            lnorm_pkg::S_VAR_ACC: begin
                n_state = i_sts.idx_last ? lnorm_pkg::S_VDIV_GO : lnorm_pkg::S_VAR_RD;
            end
            lnorm_pkg::S_VDIV_GO:  n_state = lnorm_pkg::S_VDIV_WAIT;
            lnorm_pkg::S_VDIV_WAIT: begin
                if (i_sts.div_done) n_state = lnorm_pkg::S_OUT_RD;
            end
            lnorm_pkg::S_OUT_RD:   n_state = lnorm_pkg::S_OUT_DIFF;
            lnorm_pkg::S_OUT_DIFF: n_state = lnorm_pkg::S_OUT_SQ;
            lnorm_pkg::S_OUT_SQ:   n_state = lnorm_pkg::S_OUT_SRCH;
            lnorm_pkg::S_OUT_SRCH: begin
                if (i_sts.srch_last) n_state = lnorm_pkg::S_OUT_EMIT;
            end
            lnorm_pkg::S_OUT_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.idx_last ? lnorm_pkg::S_LOAD : lnorm_pkg::S_OUT_RD;
                end
            end
            default: n_state = lnorm_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_sample_ready = 1'b0;
        unique case (r_state)
            lnorm_pkg::S_LOAD: begin
                o_sample_ready = 1'b1;
                o_cmd.load     = i_sample_valid;
            end
            lnorm_pkg::S_MEAN_GO: o_cmd.div_start = 1'b1;
            lnorm_pkg::S_MEAN_WAIT: begin
                o_cmd.take_mean = i_sts.div_done;
                o_cmd.idx_clr   = i_sts.div_done;
            end
            lnorm_pkg::S_VAR_RD:   o_cmd.rd   = 1'b1;
            lnorm_pkg::S_VAR_DIFF: o_cmd.diff = 1'b1;
            lnorm_pkg::S_VAR_SQ:   o_cmd.sq   = 1'b1;
            lnorm_pkg::S_VAR_ACC: begin
                o_cmd.acc     = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            lnorm_pkg::S_VDIV_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_var   = 1'b1;
            end
            lnorm_pkg::S_VDIV_WAIT: begin
                o_cmd.take_var = i_sts.div_done;
                o_cmd.idx_clr  = i_sts.div_done;
            end
            lnorm_pkg::S_OUT_RD:   o_cmd.rd   = 1'b1;
            lnorm_pkg::S_OUT_DIFF: o_cmd.diff = 1'b1;
            lnorm_pkg::S_OUT_SQ:   o_cmd.t2   = 1'b1;
            lnorm_pkg::S_OUT_SRCH: o_cmd.srch = 1'b1;
            lnorm_pkg::S_OUT_EMIT: begin
                o_cmd.emit    = i_sts.out_free;
                o_cmd.idx_inc = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== design/lnorm_dp.sv =====
// ----------------------------------------------------------------------------
// Layer normalization datapath
// Sample store, sums, mean and variance registers, root search and output.
// ----------------------------------------------------------------------------
`include "layer_normalization_top_assert.svh"

module lnorm_dp #(
    parameter int MAX_LENGTH   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [SAMPLE_WIDTH-1:0]              i_sample,
    input  logic                                 i_cfg_valid,
    input  logic [lnorm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lnorm_pkg::EPS_W-1:0]          i_cfg_data,
    input  logic                                 i_result_ready,
    input  lnorm_pkg::t_cmd                      i_cmd,
    output lnorm_pkg::t_sts                      o_sts,
    output logic                                 o_cfg_ready,
    output logic                                 o_result_valid,
    output logic [lnorm_pkg::NORM_W-1:0]         o_normalized,
    output logic                                 o_last_of_vector
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int CNTW = $clog2(MAX_LENGTH + 1);
    localparam int AW   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int SUMW = SW + CNTW;
    localparam int DW   = 2 * SW + CNTW;
    localparam int VW   = 2 * SW;
    localparam int SSW  = 2 * SW + 1;
    localparam int MW   = SW + lnorm_pkg::FRAC_SHIFT;
    localparam int TW   = 2 * MW;
    localparam int CW   = 2 * SW + 34;
    localparam int KW   = $clog2(lnorm_pkg::SRCH_BITS);
    localparam int NW   = lnorm_pkg::NORM_W;
    localparam logic [7:0] MAXL = 8'(MAX_LENGTH);

    logic [SW-1:0]              r_mem [MAX_LENGTH];
    logic [SW-1:0]              r_rdata;
    logic [lnorm_pkg::LEN_W-1:0] r_len;
    logic [lnorm_pkg::EPS_W-1:0] r_eps;
    logic [SUMW-1:0]            r_sum;
    logic [CNTW-1:0]            r_count;
    logic [AW-1:0]              r_idx;
    logic [SW-1:0]              r_mean;
    logic [DW-1:0]              r_ssd;
    logic [SSW-1:0]             r_s;
    logic [SW:0]                r_d;
    logic [VW-1:0]              r_sq;
    logic [TW-1:0]              r_t2;
    logic [CW-1:0]              r_p;
    logic [CW-1:0]              r_q;
    logic [NW-1:0]              r_m;
    logic [KW-1:0]              r_k;
    logic                       r_out_valid;
    logic [NW-1:0]              r_norm;
    logic                       r_last;

    logic [7:0]      w_len_eff;
    logic [7:0]      w_cnt_inc;
    logic            w_idx_last;
    logic            w_out_free;
    logic [SUMW-1:0] w_sum_neg;
    logic [SUMW-1:0] w_abs_sum;
    logic [DW-1:0]   w_dividend;
    logic [DW-1:0]   w_quot;
    logic            w_rem_nz;
    logic            w_div_done;
    logic [SW:0]     w_mq;
    logic [SW:0]     w_mq_neg;
    logic [SW:0]     w_dneg;
    logic [SW-1:0]   w_mag;
    logic            w_neg;
    logic [MW-1:0]   w_t;
    logic [4:0]      w_sh1;
    logic [4:0]      w_sh2;
    logic [CW-1:0]   w_s_ext;
    logic [CW-1:0]   w_cand;
    logic [NW-1:0]   w_lim;
    logic [NW-1:0]   w_res;
    logic [NW-1:0]   w_res_neg;

    assign w_len_eff = (r_len == '0) ? 8'd1 :
                       ({1'b0, r_len} > MAXL) ? MAXL : {1'b0, r_len};
    assign w_cnt_inc  = 8'(r_count) + 8'd1;
    assign w_idx_last = (8'(r_idx) + 8'd1) == 8'(r_count);
    assign w_out_free = !r_out_valid || i_result_ready;

    assign w_sum_neg  = -r_sum;
    assign w_abs_sum  = r_sum[SUMW-1] ? w_sum_neg : r_sum;
    assign w_dividend = i_cmd.div_var ? r_ssd : {{(DW-SUMW){1'b0}}, w_abs_sum};

    lnorm_div #(
        .DW  (DW),
        .DVW (CNTW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_count),
        .o_quotient (w_quot),
        .o_rem_nz   (w_rem_nz),
        .o_done     (w_div_done)
    );

    assign w_mq     = w_quot[SW:0] + {{SW{1'b0}}, w_rem_nz};
    assign w_mq_neg = -w_mq;

    assign w_dneg  = -r_d;
    assign w_neg   = r_d[SW];
    assign w_mag   = w_neg ? w_dneg[SW-1:0] : r_d[SW-1:0];
    assign w_t     = {w_mag, {lnorm_pkg::FRAC_SHIFT{1'b0}}};
    assign w_sh1   = {1'b0, r_k} + 5'd1;
    assign w_sh2   = {r_k, 1'b0};
    assign w_s_ext = {{(CW-SSW){1'b0}}, r_s};
    assign w_cand  = r_p + (r_q << w_sh1) + (w_s_ext << w_sh2);

    assign w_lim     = w_neg ? lnorm_pkg::NEG_LIM : lnorm_pkg::POS_LIM;
    assign w_res     = (w_mag == '0) ? '0 : ((r_m > w_lim) ? w_lim : r_m);
    assign w_res_neg = -w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= lnorm_pkg::LEN_RESET;
            r_eps       <= lnorm_pkg::EPS_RESET;
            r_sum       <= '0;
            r_count     <= '0;
            r_ssd       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lnorm_pkg::CFG_LENGTH:  r_len <= i_cfg_data[lnorm_pkg::LEN_W-1:0];
                    lnorm_pkg::CFG_EPSILON: r_eps <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_sum   <= r_sum + {{CNTW{i_sample[SW-1]}}, i_sample};
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.take_mean) begin
                r_sum <= '0;
                r_ssd <= '0;
            end
            if (i_cmd.acc) begin
                r_ssd <= r_ssd + {{CNTW{1'b0}}, r_sq};
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (w_idx_last) r_count <= '0;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[r_count[AW-1:0]] <= i_sample;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_mean) begin
            r_mean <= r_sum[SUMW-1] ? w_mq_neg[SW-1:0] : w_quot[SW-1:0];
        end
        if (i_cmd.take_var) begin
            r_s <= {1'b0, w_quot[VW-1:0]} + {{(SSW-lnorm_pkg::EPS_W){1'b0}}, r_eps};
        end
        if (i_cmd.diff) begin
            r_d <= {r_rdata[SW-1], r_rdata} - {r_mean[SW-1], r_mean};
        end
        if (i_cmd.sq) begin
            r_sq <= VW'(w_mag) * VW'(w_mag);
        end
        if (i_cmd.t2) begin
            r_t2 <= TW'(w_t) * TW'(w_t);
            r_p  <= '0;
            r_q  <= '0;
            r_m  <= '0;
            r_k  <= KW'(lnorm_pkg::SRCH_BITS - 1);
        end
        if (i_cmd.srch) begin
            r_k <= r_k - 1'b1;
            if (w_cand <= CW'(r_t2)) begin
                r_p      <= w_cand;
                r_q      <= r_q + (w_s_ext << r_k);
                r_m[r_k] <= 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_norm <= w_neg ? w_res_neg : w_res;
            r_last <= w_idx_last;
        end
    end

    assign o_sts.in_last   = w_cnt_inc >= w_len_eff;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.idx_last  = w_idx_last;
    assign o_sts.srch_last = r_k == '0;
    assign o_sts.out_free  = w_out_free;

    assign o_cfg_ready      = 1'b1;
    assign o_result_valid   = r_out_valid;
    assign o_normalized     = r_norm;
    assign o_last_of_vector = r_last;

    `LNORM_ASSERT_IMP(a_emit_free, i_cmd.emit, w_out_free)
    `LNORM_ASSERT_NEXT(a_count_clear, i_cmd.emit && w_idx_last, r_count == '0)
    `LNORM_ASSERT_IMP(a_rd_range, i_cmd.rd, 8'(r_idx) < 8'(r_count))
    `LNORM_ASSERT_IMP(a_count_max, i_cmd.load, 8'(r_count) < MAXL)

endmodule

// ===== design/layer_normalization_top.sv =====
// ----------------------------------------------------------------------------
// Layer normalization top level
// Normalizes one vector of signed Q8.8 samples to saturated Q4.12 values.
// ----------------------------------------------------------------------------
// Samples enter on the sample channel, one request a cycle while loading.
// After the last sample of a vector (vector_length, 0 acts as 1) input stalls
// while the block computes the mean with a bit-serial divider, runs a
// variance pass (store read, difference, square, accumulate per sample),
// divides again for the variance, then emits each sample in order. Each
// result takes a store read, difference, square, a 16-step root search that
// sets the rate, and an emit. last_of_vector marks the final result. The
// result sits in an output register; a stalled receiver holds it and the
// block waits before the next one. The config channel is always ready:
// index 0 sets vector_length, index 1 sets epsilon. Reset clears sums and
// counts and restores vector_length 64 and epsilon 1.
// ----------------------------------------------------------------------------
module layer_normalization_top #(
    parameter int MAX_LENGTH   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_sample_valid,
    output logic                            o_sample_ready,
    input  logic [SAMPLE_WIDTH-1:0]         i_sample,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lnorm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lnorm_pkg::EPS_W-1:0]     i_cfg_data,
    output logic                            o_result_valid,
    input  logic                            i_result_ready,
    output logic [lnorm_pkg::NORM_W-1:0]    o_normalized,
    output logic                            o_last_of_vector
);

    lnorm_pkg::t_cmd w_cmd;
    lnorm_pkg::t_sts w_sts;

    lnorm_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .i_sts          (w_sts),
        .o_sample_ready (o_sample_ready),
        .o_cmd          (w_cmd)
    );

    lnorm_dp #(
        .MAX_LENGTH   (MAX_LENGTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample         (i_sample),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_result_ready   (i_result_ready),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_cfg_ready      (o_cfg_ready),
        .o_result_valid   (o_result_valid),
        .o_normalized     (o_normalized),
        .o_last_of_vector (o_last_of_vector)
    );

endmodule
